// ----- hw/rtl/fbps_pkg.sv -----
// ---------------------------------------------------------------------------
// fbps_pkg
// types and constants shared by the falling box physics step block
// ---------------------------------------------------------------------------
package fbps_pkg;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_PLACE = 1'b1;

    localparam logic [2:0] REG_FLOOR   = 3'd0;
    localparam logic [2:0] REG_GRAVITY = 3'd1;
    localparam logic [2:0] REG_REST    = 3'd2;
    localparam logic [2:0] REG_SIZE    = 3'd3;
    localparam logic [2:0] REG_STOP    = 3'd4;

    localparam logic [30:0] FLOOR_RESET   = 31'd245760;
    localparam logic [23:0] GRAVITY_RESET = 24'd294400;
    localparam logic [8:0]  REST_RESET    = 9'd141;
    localparam logic [23:0] SIZE_RESET    = 24'd25600;
    localparam logic [23:0] STOP_RESET    = 24'd20480;

    localparam int MAX_REPORT = 8;

    typedef struct packed {
        logic               req_type;
        logic [15:0]        step_time;
        logic [3:0]         grabbed_box;
        logic [3:0]         active_count;
        logic [2:0]         box_index;
        logic signed [31:0] place_x;
        logic signed [31:0] place_y;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         out_index;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_vel;
        logic               last_box;
    } out_item_t;

    typedef struct packed {
        logic [30:0] floor_level;
        logic [23:0] gravity_accel;
        logic [8:0]  restitution;
        logic [23:0] box_size;
        logic [23:0] stop_speed;
    } cfg_t;

    // box state word as kept in memory
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] vel;
    } box_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- hw/rtl/fbps_ram.sv -----
// ---------------------------------------------------------------------------
// fbps_ram
// generic single-port synchronous ram with registered read
// ---------------------------------------------------------------------------
module fbps_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 8
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

// ----- hw/rtl/fbps_cfg.sv -----
// ---------------------------------------------------------------------------
// fbps_cfg
// apb register file for the physics constants
// ---------------------------------------------------------------------------
module fbps_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output fbps_pkg::cfg_t     cfg
);

    fbps_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.floor_level   <= fbps_pkg::FLOOR_RESET;
            cfg_reg.gravity_accel <= fbps_pkg::GRAVITY_RESET;
            cfg_reg.restitution   <= fbps_pkg::REST_RESET;
            cfg_reg.box_size      <= fbps_pkg::SIZE_RESET;
            cfg_reg.stop_speed    <= fbps_pkg::STOP_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                fbps_pkg::REG_FLOOR:   cfg_reg.floor_level   <= pwdata[30:0];
                fbps_pkg::REG_GRAVITY: cfg_reg.gravity_accel <= pwdata[23:0];
                fbps_pkg::REG_REST:    cfg_reg.restitution   <= pwdata[8:0];
                fbps_pkg::REG_SIZE:    cfg_reg.box_size      <= pwdata[23:0];
                fbps_pkg::REG_STOP:    cfg_reg.stop_speed    <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            fbps_pkg::REG_FLOOR:   prdata = {1'b0, cfg_reg.floor_level};
            fbps_pkg::REG_GRAVITY: prdata = {8'd0, cfg_reg.gravity_accel};
            fbps_pkg::REG_REST:    prdata = {23'd0, cfg_reg.restitution};
            fbps_pkg::REG_SIZE:    prdata = {8'd0, cfg_reg.box_size};
            fbps_pkg::REG_STOP:    prdata = {8'd0, cfg_reg.stop_speed};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

// ----- hw/rtl/falling_box_physics_step_top.sv -----
// ---------------------------------------------------------------------------
// falling_box_physics_step_top
// box gravity and bounce step over a state ram with one sequencer
// ---------------------------------------------------------------------------
// a place transaction reads the box and writes it back; a tick updates every box
// and scans the active boxes for contact, reading each candidate on the single ram
// port, then reports the first min(NUM_BOXES, MAX_REPORT) boxes as the output
// allows; one transaction at a time
// reset: control and config registers clear at once, then a clearing pass
// zeroes every state ram entry while input is stalled
module falling_box_physics_step_top #(
    parameter int NUM_BOXES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fbps_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output fbps_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
    localparam int CW = $clog2(NUM_BOXES + 1);
    localparam int NREP = (NUM_BOXES < fbps_pkg::MAX_REPORT) ? NUM_BOXES
                                                             : fbps_pkg::MAX_REPORT;

    typedef enum logic [13:0] {
        S_CLEAR  = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_PLRD   = 14'b00000000000100,
        S_RD_I   = 14'b00000000001000,
        S_VEL    = 14'b00000000010000,
        S_POS    = 14'b00000000100000,
        S_POSSAT = 14'b00000001000000,
        S_SCANRD = 14'b00000010000000,
        S_SCAN   = 14'b00000100000000,
        S_RPTRD  = 14'b00001000000000,
        S_BNC    = 14'b00010000000000,
        S_BNCSAT = 14'b00100000000000,
        S_WR_I   = 14'b01000000000000,
        S_REPORT = 14'b10000000000000
    } state_t;

    fbps_pkg::cfg_t cfg;

    fbps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t           state_reg, state_next;
    logic [CW-1:0]    i_reg, i_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [CW-1:0]    act_reg;
    logic [CW-1:0]    held_reg;
    logic [15:0]      dt_reg;
    logic             hit_reg, hit_next;
    logic signed [63:0] surf_reg, surf_next;
    fbps_pkg::box_t   cur_reg, cur_next;
    logic signed [63:0] prod_reg, prod_next;
    fbps_pkg::in_item_t pl_reg;
    logic             ov_reg, ov_next;
    fbps_pkg::out_item_t od_reg, od_next;

    logic             we;
    logic [AW-1:0]    addr;
    fbps_pkg::box_t   wdata, rdata;

    fbps_ram #(.WIDTH($bits(fbps_pkg::box_t)), .DEPTH(NUM_BOXES)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
        logic signed [63:0] q;
        q = p + 64'sd32768;
        return q >>> 16;
    endfunction

    logic signed [63:0] sz;
    logic               ovl;
    assign sz = {40'd0, cfg.box_size};
    // overlap of the current box against the other box just read
    assign ovl = (64'(cur_reg.y) + sz > 64'(rdata.y)) && (64'(cur_reg.y) < 64'(rdata.y) + sz)
              && (64'(cur_reg.x) + sz > 64'(rdata.x)) && (64'(cur_reg.x) < 64'(rdata.x) + sz);

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        hit_next = hit_reg;
        surf_next = surf_reg;
        cur_next = cur_reg;
        prod_next = prod_reg;
        ov_next = ov_reg;
        od_next = od_reg;
        we = 1'b0;
        addr = i_reg[AW-1:0];
        wdata = cur_reg;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                wdata = '0;
                i_next = i_reg + 1'b1;
                if (i_reg == CW'(NUM_BOXES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.req_type == fbps_pkg::REQ_PLACE)
                    begin
                        if (32'(in_data.box_index) < NUM_BOXES)
                        begin
                            addr = AW'(in_data.box_index);
                            state_next = S_PLRD;
                        end
                    end
                    else
                    begin
                        i_next = '0;
                        state_next = S_RD_I;
                    end
                end
            end
            S_PLRD:
            begin
                addr = AW'(pl_reg.box_index);
                we = 1'b1;
                wdata.x = pl_reg.place_x;
                wdata.y = pl_reg.place_y;
                wdata.vel = rdata.vel;
                state_next = S_IDLE;
            end
            S_RD_I:
            begin
                state_next = S_VEL;
                prod_next = $signed({40'd0, cfg.gravity_accel}) * $signed({48'd0, dt_reg});
            end
            S_VEL:
            begin
                cur_next = rdata;
                if (i_reg == held_reg)
                begin
                    cur_next.vel = '0;
                    state_next = S_WR_I;
                end
                else
                begin
                    cur_next.vel = fbps_pkg::sat32(64'(rdata.vel) + rnd16(prod_reg));
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                prod_next = 64'(cur_reg.vel) * $signed({48'd0, dt_reg});
                state_next = S_POSSAT;
            end
            S_POSSAT:
            begin
                cur_next.y = fbps_pkg::sat32(64'(cur_reg.y) + rnd16(prod_reg));
                hit_next = 1'b0;
                surf_next = {33'd0, cfg.floor_level};
                j_next = '0;
                state_next = S_SCANRD;
            end
            S_SCANRD:
            begin
                // skip self; stop at end of active range
                if (j_reg >= act_reg)
                begin
                    if (64'(cur_reg.y) + sz > $signed({33'd0, cfg.floor_level}))
                    begin
                        hit_next = 1'b1;
                        surf_next = {33'd0, cfg.floor_level};
                    end
                    state_next = S_BNC;
                    if (!(hit_reg || (64'(cur_reg.y) + sz > $signed({33'd0, cfg.floor_level}))))
                        state_next = S_WR_I;
                end
                else if (j_reg == i_reg)
                    j_next = j_reg + 1'b1;
                else
                begin
                    addr = j_reg[AW-1:0];
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                addr = j_reg[AW-1:0];
                if (ovl)
                begin
                    hit_next = 1'b1;
                    surf_next = 64'(rdata.y);
                    if (rdata.vel != 0)
                    begin
                        // equal masses: trade velocities
                        we = 1'b1;
                        wdata = rdata;
                        wdata.vel = cur_reg.vel;
                        cur_next.vel = rdata.vel;
                        state_next = S_WR_I;
                    end
                    else
                        state_next = S_BNC;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = S_SCANRD;
                end
            end
            S_BNC:
            begin
                cur_next.y = fbps_pkg::sat32(surf_reg - sz);
                prod_next = -(64'(cur_reg.vel) * $signed({55'd0, cfg.restitution}));
                state_next = S_BNCSAT;
            end
            S_BNCSAT:
            begin
                cur_next.vel = fbps_pkg::sat32((prod_reg + 64'sd128) >>> 8);
                if ((cur_next.vel < 0 ? -64'(cur_next.vel) : 64'(cur_next.vel))
                    < {40'd0, cfg.stop_speed})
                    cur_next.vel = '0;
                state_next = S_WR_I;
            end
            S_WR_I:
            begin
                we = 1'b1;
                if (i_reg == CW'(NUM_BOXES - 1))
                begin
                    i_next = '0;
                    state_next = S_RPTRD;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = S_RD_I;
                end
            end
            S_RPTRD:
                // read of entry 0 for the first report
                state_next = S_REPORT;
            S_REPORT:
            begin
                // rdata holds entry i_reg; load it when the output is free
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    od_next.out_index = 3'(i_reg);
                    od_next.out_x = rdata.x;
                    od_next.out_y = rdata.y;
                    od_next.out_vel = rdata.vel;
                    od_next.last_box = (i_reg == CW'(NREP - 1));
                    i_next = i_reg + 1'b1;
                    addr = AW'(i_reg + 1'b1);
                    if (i_reg == CW'(NREP - 1))
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            i_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg <= j_next;
        hit_reg <= hit_next;
        surf_reg <= surf_next;
        cur_reg <= cur_next;
        prod_reg <= prod_next;
        od_reg <= od_next;
        if (state_reg == S_IDLE && in_valid)
        begin
            pl_reg <= in_data;
            dt_reg <= in_data.step_time;
            held_reg <= (32'(in_data.grabbed_box) >= NUM_BOXES) ? CW'(NUM_BOXES)
                                                               : CW'(in_data.grabbed_box);
            act_reg <= (32'(in_data.active_count) > NUM_BOXES) ? CW'(NUM_BOXES)
                                                               : CW'(in_data.active_count);
        end
    end

endmodule

// ----- bench/falling_box_physics_step_top_tb.sv -----
// ---------------------------------------------------------------------------
// falling_box_physics_step_top_tb
// drives place and tick transactions with random gaps and stalls, predicts
// every box report with a behavioral copy of the physics step, and compares
// ---------------------------------------------------------------------------
module falling_box_physics_step_top_tb;
    import fbps_pkg::*;

    localparam int NB = 8;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    falling_box_physics_step_top #(.NUM_BOXES(NB)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor copy of the configuration and box state
    cfg_t                 phys_cfg;
    logic signed [31:0]   px [NB];
    logic signed [31:0]   py [NB];
    logic signed [31:0]   pv [NB];

    out_item_t   box_reports[$];
    int          mismatches;
    int          hold_cycles;
    bit          hold_req;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // floor((p + 2^(s-1)) / 2^s)
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] p,
                                                     input int s);
        logic signed [63:0] q;
        q = p + (64'sd1 <<< (s - 1));
        return q >>> s;
    endfunction

    function automatic bit boxes_touch(input int a, input int b);
        logic signed [63:0] sz;
        sz = {40'd0, phys_cfg.box_size};
        return (64'(py[a]) + sz > 64'(py[b])) && (64'(py[a]) < 64'(py[b]) + sz) &&
               (64'(px[a]) + sz > 64'(px[b])) && (64'(px[a]) < 64'(px[b]) + sz);
    endfunction

    task automatic predict_step(input in_item_t it);
        logic signed [63:0] dt;
        logic signed [63:0] sz;
        logic signed [63:0] surface;
        logic signed [63:0] v;
        logic signed [31:0] t;
        int                 act;
        bit                 hit;
        bit                 moving;
        out_item_t          r;
        if (it.req_type == REQ_PLACE)
        begin
            px[it.box_index] = it.place_x;
            py[it.box_index] = it.place_y;
            return;
        end
        dt = {48'd0, it.step_time};
        sz = {40'd0, phys_cfg.box_size};
        act = (it.active_count > NB) ? NB : it.active_count;
        for (int i = 0; i < NB; i++)
        begin
            hit = 0;
            moving = 0;
            surface = {33'd0, phys_cfg.floor_level};
            if (i == it.grabbed_box)
            begin
                pv[i] = 0;
                continue;
            end
            pv[i] = clamp32(64'(pv[i]) + rnd_shift({40'd0, phys_cfg.gravity_accel} * dt, 16));
            py[i] = clamp32(64'(py[i]) + rnd_shift(64'(pv[i]) * dt, 16));
            for (int j = 0; j < act; j++)
            begin
                if (j == i)
                    continue;
                if (boxes_touch(i, j))
                begin
                    hit = 1;
                    if (pv[j] != 0)
                    begin
                        t = pv[i];
                        moving = 1;
                        pv[i] = pv[j];
                        pv[j] = t;
                    end
                    surface = 64'(py[j]);
                    break;
                end
            end
            if (!hit && (64'(py[i]) + sz > $signed({33'd0, phys_cfg.floor_level})))
            begin
                hit = 1;
                surface = {33'd0, phys_cfg.floor_level};
            end
            if (hit && !moving)
            begin
                py[i] = clamp32(surface - sz);
                pv[i] = clamp32(rnd_shift(-64'(pv[i]) * {55'd0, phys_cfg.restitution}, 8));
                v = 64'(pv[i]);
                if (v < 0)
                    v = -v;
                if (v < {40'd0, phys_cfg.stop_speed})
                    pv[i] = 0;
            end
        end
        for (int n = 0; n < MAX_REPORT; n++)
        begin
            r.out_index = n[2:0];
            r.out_x = px[n];
            r.out_y = py[n];
            r.out_vel = pv[n];
            r.last_box = (n == MAX_REPORT - 1);
            box_reports.push_back(r);
        end
    endtask

    // receiver: own stall pattern plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cycles <= 0;
        end
        else if (hold_req && hold_cycles == 0)
        begin
            hold_cycles <= 400;
            out_stall <= 1'b1;
        end
        else if (hold_cycles > 1)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            hold_cycles <= 0;
            out_stall <= ($urandom_range(0, 99) < 30) && ($urandom_range(0, 3) != 0);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (box_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected box report %p", out_data);
            end
            else
            begin
                e = box_reports.pop_front();
                if (out_data !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("box report mismatch: expected %p actual %p", e, out_data);
                end
            end
        end
    end

    task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (reg_idx)
            REG_FLOOR:   phys_cfg.floor_level = val[30:0];
            REG_GRAVITY: phys_cfg.gravity_accel = val[23:0];
            REG_REST:    phys_cfg.restitution = val[8:0];
            REG_SIZE:    phys_cfg.box_size = val[23:0];
            REG_STOP:    phys_cfg.stop_speed = val[23:0];
            default: ;
        endcase
    endtask

    // wait for drain, then the tail of a place that reports nothing
    task automatic drain_all();
        in_valid <= 1'b0;
        while (box_reports.size() != 0)
            @(posedge clk);
        repeat (NB * (NB + 12) + 20)
            @(posedge clk);
    endtask

    // sender; predicts at acceptance, valid stays up for the next transaction
    task automatic send_item(input in_item_t it);
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_step(it);
    endtask

    task automatic send_burst(input in_item_t it, input bit gaps);
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
        send_item(it);
    endtask

    function automatic in_item_t make_tick(input logic [15:0] dt, input logic [3:0] g,
                                           input logic [3:0] a);
        in_item_t it;
        it = '0;
        it.req_type = REQ_TICK;
        it.step_time = dt;
        it.grabbed_box = g;
        it.active_count = a;
        it.place_x = $urandom;
        it.place_y = $urandom;
        it.box_index = 3'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_place(input logic [2:0] k, input logic signed [31:0] x,
                                            input logic signed [31:0] y);
        in_item_t it;
        it = '0;
        it.req_type = REQ_PLACE;
        it.box_index = k;
        it.place_x = x;
        it.place_y = y;
        it.step_time = 16'($urandom);
        it.grabbed_box = 4'($urandom);
        it.active_count = 4'($urandom);
        return it;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return make_place(3'($urandom), $signed($urandom_range(0, 40)) * 6400,
                              $signed($urandom_range(0, 60)) * 6400 - 100000);
        if (pick < 50)
            return make_place(3'($urandom), $urandom, $urandom);
        return make_tick((pick < 55) ? 16'($urandom) : 16'($urandom_range(200, 3000)),
                         4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    endfunction

    // directed table; expected reports of the first row read straight off reset state
    in_item_t dir_tab[$];

    initial
    begin
        out_item_t z;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        mismatches = 0;
        phys_cfg.floor_level = FLOOR_RESET;
        phys_cfg.gravity_accel = GRAVITY_RESET;
        phys_cfg.restitution = REST_RESET;
        phys_cfg.box_size = SIZE_RESET;
        phys_cfg.stop_speed = STOP_RESET;
        for (int i = 0; i < NB; i++)
        begin
            px[i] = 0;
            py[i] = 0;
            pv[i] = 0;
        end
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-length tick at reset with no box grabbed and no active boxes: nothing moves
        send_item(make_tick(16'd0, 4'd8, 4'd0));
        for (int n = 0; n < MAX_REPORT; n++)
        begin
            z = box_reports[n];
            if (z.out_x !== 0 || z.out_y !== 0 || z.out_vel !== 0 ||
                z.last_box !== (n == MAX_REPORT - 1))
            begin
                mismatches++;
                $display("reset tick row %0d wrong prediction", n);
            end
        end

        dir_tab.push_back(make_place(3'd0, 32'sh7fffffff, 32'sh80000000));
        dir_tab.push_back(make_place(3'd7, 32'sh80000000, 32'sh7fffffff));
        dir_tab.push_back(make_tick(16'hffff, 4'd15, 4'd15));
        dir_tab.push_back(make_place(3'd1, 0, 0));
        dir_tab.push_back(make_place(3'd2, 0, 12800));
        dir_tab.push_back(make_place(3'd3, 0, 200000));
        dir_tab.push_back(make_tick(16'd1000, 4'd8, 4'd8));
        dir_tab.push_back(make_tick(16'd1000, 4'd2, 4'd4));
        dir_tab.push_back(make_tick(16'd2000, 4'd0, 4'd9));
        dir_tab.push_back(make_tick(16'd1, 4'd7, 4'd1));
        dir_tab.push_back(make_place(3'd4, 32'sd300000, 32'sd230000));
        dir_tab.push_back(make_tick(16'd5000, 4'd8, 4'd8));
        dir_tab.push_back(make_tick(16'h8000, 4'd3, 4'd8));
        foreach (dir_tab[k])
            send_item(dir_tab[k]);
        drain_all();

        // several settings, extremes among them
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin
                    apb_write(REG_FLOOR, 32'h7fffffff);
                    apb_write(REG_GRAVITY, 32'hffffff);
                    apb_write(REG_REST, 32'd256);
                    apb_write(REG_SIZE, 32'hffffff);
                    apb_write(REG_STOP, 32'd0);
                end
                1: begin
                    apb_write(REG_FLOOR, 32'd0);
                    apb_write(REG_GRAVITY, 32'd0);
                    apb_write(REG_REST, 32'd0);
                    apb_write(REG_SIZE, 32'd256);
                    apb_write(REG_STOP, 32'hffffff);
                end
                2: begin
                    apb_write(REG_FLOOR, 32'd245760);
                    apb_write(REG_GRAVITY, 32'd294400);
                    apb_write(REG_REST, 32'd300 + $urandom_range(0, 211));
                    apb_write(REG_SIZE, 32'd25600);
                    apb_write(REG_STOP, 32'd2000);
                end
                default: begin
                    apb_write(REG_FLOOR, $urandom);
                    apb_write(REG_GRAVITY, $urandom);
                    apb_write(REG_REST, $urandom_range(0, 256));
                    apb_write(REG_SIZE, $urandom_range(256, 50000));
                    apb_write(REG_STOP, $urandom_range(0, 40000));
                end
            endcase
            for (int k = 0; k < 72; k++)
            begin
                if (ph == 1 && k == 10)
                    hold_req = 1'b1;
                if (ph == 1 && k == 11)
                    hold_req = 1'b0;
                if (ph == 2 && k == 30)
                begin
                    in_valid <= 1'b0;
                    while (box_reports.size() != 0)
                        @(posedge clk);
                end
                send_burst(rand_item(), 1'b1);
            end
            drain_all();
        end

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
